@@ design/sds_pkg.sv @@
package sds_pkg;

    localparam int NUM_PERIPH = 8;
    localparam int IDX_W      = (NUM_PERIPH > 1) ? $clog2(NUM_PERIPH) : 1;
    localparam int TIME_W     = 64;
    localparam logic [TIME_W-1:0] DEADLINE_NEVER = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SYNC    = 3'd1,
        OP_SET     = 3'd2,
        OP_CLOSER  = 3'd3,
        OP_DISABLE = 3'd4,
        OP_RESCAN  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  peripheral;
        logic [31:0] amount;
    } t_in_word;

    typedef struct packed {
        logic [63:0] elapsed;
        logic        sync_pending;
        logic        peripheral_due;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

@@ design/sds_ctrl.sv @@
module sds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [2:0]       i_op,
    input  sds_pkg::t_status i_status,
    output sds_pkg::t_cmd    o_cmd,
    output logic             busy
);

    sds_pkg::t_state r_state;
    sds_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sds_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (i_op == sds_pkg::OP_RESCAN) ? sds_pkg::ST_SCAN
                                                           : sds_pkg::ST_EXEC;
                end
            end
            sds_pkg::ST_EXEC:   n_state = sds_pkg::ST_REPORT;
            sds_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = sds_pkg::ST_REPORT;
                end
            end
            sds_pkg::ST_REPORT: n_state = sds_pkg::ST_IDLE;
            default:            n_state = sds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            sds_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            sds_pkg::ST_EXEC:   o_cmd.exec      = 1'b1;
            sds_pkg::ST_SCAN:   o_cmd.scan_step = 1'b1;
            sds_pkg::ST_REPORT: o_cmd.report    = 1'b1;
            default:            busy            = 1'b1;
        endcase
    end

    // a scan always runs to its last entry before the report
    a_scan_to_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sds_pkg::ST_SCAN && i_status.scan_last)
            |=> r_state == sds_pkg::ST_REPORT)
        else $error("scan did not hand over to report");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sds_pkg::ST_EXEC |=> r_state == sds_pkg::ST_REPORT)
        else $error("exec lasted more than one cycle");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.scan_step, o_cmd.report}))
        else $error("conflicting datapath commands");

endmodule

@@ design/sds_dp.sv @@
module sds_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sds_pkg::t_in_word  i_item,
    input  sds_pkg::t_cmd      i_cmd,
    output sds_pkg::t_status   o_status,
    output sds_pkg::t_out_word o_result,
    output logic               o_strobe
);

    localparam int IdxW  = sds_pkg::IDX_W;
    localparam int NumP  = sds_pkg::NUM_PERIPH;
    localparam int TimeW = sds_pkg::TIME_W;

    sds_pkg::t_in_word  r_item;
    logic [TimeW-1:0]   r_time;
    logic [TimeW-1:0]   r_earliest;
    logic [TimeW-1:0]   r_last [NumP];
    logic [TimeW-1:0]   r_dead [NumP];
    logic [TimeW-1:0]   r_min;
    logic [TimeW-1:0]   r_elapsed;
    logic [IdxW-1:0]    r_scan_idx;
    sds_pkg::t_out_word r_result;
    logic               r_strobe;

    logic [IdxW-1:0]    p_idx;
    logic [IdxW-1:0]    rd_idx;
    logic               p_ok;
    logic [TimeW-1:0]   rd_dead;
    logic [TimeW-1:0]   date;
    logic [TimeW-1:0]   n_min;
    logic               scan_last;

    assign p_idx     = IdxW'(r_item.peripheral);
    assign p_ok      = 32'(r_item.peripheral) < 32'(NumP);
    assign rd_idx    = i_cmd.scan_step ? r_scan_idx : p_idx;
    assign rd_dead   = r_dead[rd_idx];
    assign date      = r_time + TimeW'(r_item.amount);
    assign n_min     = (rd_dead < r_min) ? rd_dead : r_min;
    assign scan_last = r_scan_idx == IdxW'(NumP - 1);

    assign o_status.scan_last = scan_last;
    assign o_result           = r_result;
    assign o_strobe           = r_strobe;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_earliest <= '0;
            r_elapsed  <= '0;
            r_min      <= sds_pkg::DEADLINE_NEVER;
            r_scan_idx <= '0;
            for (int k = 0; k < NumP; k++) begin
                r_last[k] <= '0;
                r_dead[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_elapsed  <= '0;
                r_min      <= sds_pkg::DEADLINE_NEVER;
                r_scan_idx <= '0;
            end
            if (i_cmd.scan_step) begin
                r_min      <= n_min;
                r_scan_idx <= r_scan_idx + IdxW'(1);
                if (scan_last) begin
                    r_earliest <= n_min;
                end
            end
            if (i_cmd.exec) begin
                case (r_item.op)
                    sds_pkg::OP_TICK: r_time <= date;
                    sds_pkg::OP_SYNC: begin
                        if (p_ok) begin
                            r_elapsed     <= r_time - r_last[p_idx];
                            r_last[p_idx] <= r_time;
                        end
                    end
                    sds_pkg::OP_SET: begin
                        if (p_ok) begin
                            r_dead[p_idx] <= date;
                            if (date < r_earliest) begin
                                r_earliest <= date;
                            end
                        end
                    end
                    sds_pkg::OP_CLOSER: begin
                        if (p_ok && rd_dead > date) begin
                            r_dead[p_idx] <= date;
                        end
                    end
                    sds_pkg::OP_DISABLE: begin
                        if (p_ok) begin
                            r_dead[p_idx] <= sds_pkg::DEADLINE_NEVER;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // flags are taken from the state after the op has landed
    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_result.elapsed        <= r_elapsed;
            r_result.sync_pending   <= r_earliest <= r_time;
            r_result.peripheral_due <= p_ok && (rd_dead <= r_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.report;
        end
    end

    a_scan_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step && scan_last |=> r_earliest <= $past(rd_dead))
        else $error("rescan minimum above last entry");

    a_elapsed_sync_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && r_item.op != sds_pkg::OP_SYNC |-> o_result.elapsed == '0)
        else $error("elapsed set for a non-sync word");

endmodule

@@ design/sync_deadline_scheduler_top.sv @@
// Deadline scheduler: a 64-bit clock advanced by tick words, per-peripheral
// last-sync and deadline dates, and a global earliest deadline.
// Input: a word (op, peripheral, amount) is taken on a clock edge with
// start high and busy low. Ops: tick, sync, set deadline, set if closer,
// disable, rescan minimum.
// Output: each word gives one result on o_result, held until the next and
// marked by o_strobe for one cycle; it cannot be held off by the receiver.
// Steps: the op is applied in the exec state, then the flags and the result
// are registered in the report state, and the strobe follows. busy drops
// in the strobe cycle, so the next word can be taken there; no new word is
// taken while the last one is still being worked on.
// Rescan walks the deadline table one entry a cycle through a single
// compare, in place of the exec state, and then reports.
// Reset clears the clock, all dates and the earliest deadline to zero, so
// both flags read 1 until later deadlines are set and, for sync, rescanned.
module sync_deadline_scheduler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sds_pkg::t_in_word  i_item,
    output logic               busy,
    output sds_pkg::t_out_word o_result,
    output logic               o_strobe
);

    sds_pkg::t_cmd    cmd;
    sds_pkg::t_status status;

    sds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sds_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("word accepted but block not busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe outside end of work");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

endmodule
